// File: hdl/set_assoc_lru_cache_sim_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache core
// Concurrent checks used by the core file that asserts.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc: next-cycle check failed");

`endif

// File: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared constants and types of the set-associative LRU cache core.
// ----------------------------------------------------------------------------
package slc_pkg;

  // Geometry defaults
  localparam int TOTAL_LINES_DEF = 512;
  localparam int OFFSET_BITS_DEF = 5;
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int MAX_WAYS_DEF    = 16;

  // Fixed field widths
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 3;

  localparam logic [CFG_W-1:0] WAYS_LOG2_RST = CFG_W'(1);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } slc_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch address fields, read the set's row
    logic update;   // compare, write row back, post result
  } slc_cmd_t;

endpackage

// File: hdl/slc_ram.sv
// ----------------------------------------------------------------------------
// slc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/slc_ctrl.sv
// ----------------------------------------------------------------------------
// slc_ctrl
// Access sequencer: accept, then a lookup/update state.
// ----------------------------------------------------------------------------
module slc_ctrl
  import slc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  output slc_cmd_t cmd_o
);

  slc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy_o        = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = start_i;
      end
      ST_LOOKUP: begin
        busy_o       = 1'b1;
        cmd_o.update = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

endmodule

// File: hdl/slc_dp.sv
// ----------------------------------------------------------------------------
// slc_dp
// Tag/age/valid row store, tag compare, LRU update and hit counter.
// ----------------------------------------------------------------------------
module slc_dp
  import slc_pkg::*;
#(
  parameter int TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
  parameter int MAX_WAYS    = MAX_WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slc_cmd_t              cmd_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  input  logic                  ways_log2_we_i,
  input  logic [CFG_W-1:0]      ways_log2_i,
  output logic                  hit_o,
  output logic [COUNT_W-1:0]    hit_count_o,
  output logic                  done_o
);

  localparam int LINES_LOG2 = $clog2(TOTAL_LINES);
  localparam int MW_LOG2    = $clog2(MAX_WAYS);
  localparam int ROWS       = TOTAL_LINES / MAX_WAYS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int BLOCK_W    = ADDR_WIDTH - OFFSET_BITS;
  localparam int TAG_W      = BLOCK_W - (LINES_LOG2 - MW_LOG2);
  localparam int AGE_W      = MW_LOG2;
  localparam int LANE_W     = 1 + AGE_W + TAG_W;
  localparam int SH_W       = $clog2(LINES_LOG2 + 1);
  localparam int MAX_K      = (MW_LOG2 > 4) ? 4 : MW_LOG2;

  // Effective log2 of associativity (clamped on write)
  logic [CFG_W-1:0] k_q;
  logic [ROWS-1:0]  rvalid_q;   // row written since reset / last reconfig
  logic [TAG_W-1:0] tag_q;
  logic [MW_LOG2-1:0] off_q;
  logic [ROW_W-1:0] row_q;
  logic [COUNT_W-1:0] count_q;
  logic             hit_q;
  logic             done_q;

  // Address split
  logic [BLOCK_W-1:0]    block;
  logic [LINES_LOG2-1:0] base;
  logic [SH_W-1:0]       shamt;
  logic [TAG_W-1:0]      tag_new;
  logic [ROW_W-1:0]      row_new;

  // Row data
  logic [MAX_WAYS*LANE_W-1:0] rdata;
  logic [MAX_WAYS*LANE_W-1:0] wdata;

  // Lookup
  logic [MW_LOG2:0]     ways_full;
  logic [MW_LOG2-1:0]   wmask;
  logic                 row_ok;
  logic [MAX_WAYS-1:0]  in_set;
  logic [MAX_WAYS-1:0]  match;
  logic [MAX_WAYS-1:0]  victim;
  logic [MAX_WAYS-1:0]  sel;
  logic [MAX_WAYS-1:0]  l_valid;
  logic [AGE_W-1:0]     l_age [MAX_WAYS];
  logic [TAG_W-1:0]     l_tag [MAX_WAYS];
  logic                 hit;
  logic [MW_LOG2-1:0]   target;
  logic [AGE_W-1:0]     oldage;
  logic [CFG_W-1:0]     k_wr;

  assign block   = address_i[ADDR_WIDTH-1:OFFSET_BITS];
  assign base    = LINES_LOG2'(block[LINES_LOG2-1:0] << k_q);
  assign shamt   = SH_W'(LINES_LOG2) - SH_W'(k_q);
  assign tag_new = TAG_W'(block >> shamt);
  assign row_new = base[LINES_LOG2-1:MW_LOG2];

  // Clamp of the associativity register
  always_comb begin
    if (ways_log2_i < CFG_W'(1)) begin
      k_wr = CFG_W'(1);
    end else if (ways_log2_i > CFG_W'(MAX_K)) begin
      k_wr = CFG_W'(MAX_K);
    end else begin
      k_wr = ways_log2_i;
    end
  end

  slc_ram #(
    .WIDTH (MAX_WAYS * LANE_W),
    .DEPTH (ROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (row_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (row_new),
    .rdata_o (rdata)
  );

  assign ways_full = (MW_LOG2 + 1)'(1) << k_q;
  assign wmask     = MW_LOG2'(ways_full - (MW_LOG2 + 1)'(1));
  assign row_ok    = rvalid_q[row_q];

  // Unpack lanes; a row never written reads as the reset pattern
  always_comb begin
    for (int l = 0; l < MAX_WAYS; l++) begin
      l_tag[l]   = rdata[l*LANE_W +: TAG_W];
      l_valid[l] = row_ok & rdata[l*LANE_W + LANE_W - 1];
      l_age[l]   = row_ok ? rdata[l*LANE_W + TAG_W +: AGE_W]
                          : AGE_W'(MW_LOG2'(l) & wmask);
      in_set[l]  = (MW_LOG2'(l) & ~wmask) == off_q;
      match[l]   = in_set[l] & l_valid[l] & (l_tag[l] == tag_q);
      victim[l]  = in_set[l] & (l_age[l] == AGE_W'(wmask));
    end
  end

  assign hit = |match;
  assign sel = hit ? match : victim;

  always_comb begin
    target = '0;
    for (int l = MAX_WAYS - 1; l >= 0; l--) begin
      if (sel[l]) begin
        target = MW_LOG2'(l);
      end
    end
  end

  assign oldage = l_age[target];

  // Aged row for write-back
  always_comb begin
    for (int l = 0; l < MAX_WAYS; l++) begin
      wdata[l*LANE_W +: LANE_W] = {l_valid[l], l_age[l], l_tag[l]};
      if (in_set[l]) begin
        if (MW_LOG2'(l) == target) begin
          wdata[l*LANE_W +: LANE_W] = {1'b1, {AGE_W{1'b0}}, hit ? l_tag[l] : tag_q};
        end else if (l_age[l] < oldage) begin
          wdata[l*LANE_W +: LANE_W] = {l_valid[l], AGE_W'(l_age[l] + AGE_W'(1)), l_tag[l]};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q <= tag_new;
      off_q <= base[MW_LOG2-1:0];
      row_q <= row_new;
    end
    if (cmd_i.update) begin
      hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= WAYS_LOG2_RST;
      rvalid_q <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.update;
      if (ways_log2_we_i) begin
        k_q      <= k_wr;
        rvalid_q <= '0;
      end else if (cmd_i.update) begin
        rvalid_q[row_q] <= 1'b1;
      end
      if (cmd_i.update && hit && (count_q != {COUNT_W{1'b1}})) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  assign hit_o       = hit_q;
  assign hit_count_o = count_q;
  assign done_o      = done_q;

endmodule

// File: hdl/set_assoc_lru_cache_sim_core.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_core
// Tag-only set-associative cache with true LRU per set and a hit counter.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | beat taken when
//  ---------+----------------------------------------+--------------------------
//  access   | start_i, address_i, busy_o             | start_i & !busy_o
//  result   | done_o, hit_o, hit_count_o             | done_o (one cycle)
//  config   | ways_log2_we_i, ways_log2_i            | ways_log2_we_i
//
//  An access beat: the accept edge reads the set's row from the row RAM, then
//  the lookup state compares the set's ways, ages the set and writes the row
//  back. The single row RAM port pair keeps the read and the write-back apart.
//  done_o rises the cycle after the write-back, while a new beat may be taken.
//  Reset leaves every row marked unwritten (no clearing pass); a row that was
//  never written reads as invalid lines with ages equal to their way index in the set.
//  A ways_log2 write marks all rows unwritten again; the hit count is kept.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_core_defines.svh"

module set_assoc_lru_cache_sim_core
  import slc_pkg::*;
#(
  parameter int TOTAL_LINES = TOTAL_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
  parameter int MAX_WAYS    = MAX_WAYS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // access
  input  logic                  start_i,
  input  logic [ADDR_WIDTH-1:0] address_i,
  output logic                  busy_o,
  // result
  output logic                  done_o,
  output logic                  hit_o,
  output logic [COUNT_W-1:0]    hit_count_o,
  // config
  input  logic                  ways_log2_we_i,
  input  logic [CFG_W-1:0]      ways_log2_i
);

  slc_cmd_t cmd;

  // Sequencer: idle/lookup
  slc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // Row store, compare, LRU aging, counter
  slc_dp #(
    .TOTAL_LINES (TOTAL_LINES),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .MAX_WAYS    (MAX_WAYS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .address_i      (address_i),
    .ways_log2_we_i (ways_log2_we_i),
    .ways_log2_i    (ways_log2_i),
    .hit_o          (hit_o),
    .hit_count_o    (hit_count_o),
    .done_o         (done_o)
  );

  // Accepted beat goes into the lookup cycle
  `SLC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // Lookup cycle always yields exactly one result beat next
  `SLC_ASSERT_NEXT(a_lookup_done, clk_i, rst_ni, busy_o, done_o && !busy_o)
  // Result strobes never come back to back
  `SLC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // A miss leaves the hit count unchanged
  `SLC_ASSERT_IMPLY(a_miss_count, clk_i, rst_ni, done_o && !hit_o,
                    hit_count_o == $past(hit_count_o))

endmodule
